@@ hw/rtl/ble_midi_packet_parser_macros.svh @@
// ---------------------------------------------------------------------------
// BLE MIDI packet parser assertion macros
// Shared concurrent assertion forms, all reset-qualified.
// ---------------------------------------------------------------------------
`ifndef BLE_MIDI_PACKET_PARSER_MACROS_SVH
`define BLE_MIDI_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bmp_pkg.sv @@
// ---------------------------------------------------------------------------
// BLE MIDI packet parser package
// Parse phases, error codes, status constants and the MIDI message size table.
// ---------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_EXPECT_TS = 3'd1,
		PH_AFTER_TS  = 3'd2,
		PH_DATA      = 3'd3,
		PH_SYSEX     = 3'd4
	} phase_t;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_TOO_SHORT  = 3'd1;
	localparam logic [2:0] ERR_NO_TS_HIGH = 3'd2;
	localparam logic [2:0] ERR_NO_TS_LOW  = 3'd3;
	localparam logic [2:0] ERR_INCOMPLETE = 3'd4;

	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam int         LEN_W        = 11;   // packet length plus headroom
	localparam int         MIN_PKT_LEN  = 3;

	// Data bytes following a status byte (channel table, then system table).
	function automatic logic [1:0] msg_size(input logic [7:0] st);
		logic [1:0] n;
		case (st[6:4])
			3'd4, 3'd5: n = 2'd1;
			3'd7: begin
				case (st[3:0])
					4'h0, 4'h1, 4'h3: n = 2'd1;
					4'h2:             n = 2'd2;
					default:          n = 2'd0;
				endcase
			end
			default: n = 2'd2;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ble_midi_packet_parser.sv @@
// ---------------------------------------------------------------------------
// BLE MIDI packet parser
// Byte-serial decoder of BLE MIDI packets into MIDI messages and sysex bytes.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one packet byte per transfer with
//    its port, the packet length and a flag marking the header byte.
//  - Output channel (out_valid / out_stall): at most one result per input
//    byte: a complete message, one sysex data byte, or an error.
//  - Path: a byte is captured in the input register on its transfer and
//    decoded, once the result register can take a result, into the result
//    register; the result then shows on out_valid until it transfers.
//  - Throughput: one byte per cycle while no result waits under out_stall;
//    the decode is one pass of table lookup and compare between the two registers.
//  - Stall: while a result waits under out_stall the input register keeps
//    its byte and in_stall rises only when that register is occupied; a byte
//    that makes no result still waits for the output register to free up.
//  - Reset: arst_n clears both registers' valid flags, the parse state and
//    all per-port sysex offsets; the parser waits for a packet header.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ble_midi_packet_parser_macros.svh"

module ble_midi_packet_parser #(
	parameter int NUM_PORTS      = 4,
	parameter int MAX_PACKET_LEN = 512,
	parameter int SYSEX_POS_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  port_index,
	input  wire logic [7:0]  data_byte,
	input  wire logic [9:0]  packet_length,
	input  wire logic        first_of_packet,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_port,
	output logic [12:0]      timestamp,
	output logic [7:0]       msg_status,
	output logic [6:0]       data_first,
	output logic [6:0]       data_second,
	output logic [1:0]       data_count,
	output logic             is_sysex_byte,
	output logic [15:0]      sysex_offset,
	output logic [2:0]       error_code
);

	localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam logic [bmp_pkg::LEN_W-1:0] MAX_LEN = bmp_pkg::LEN_W'(MAX_PACKET_LEN);

	// Input register
	logic                      valid_s1;
	logic [1:0]                port_s1;
	logic [7:0]                byte_s1;
	logic [9:0]                len_s1;
	logic                      first_s1;

	// Parse state
	bmp_pkg::phase_t           phase_q, phase_d;
	logic [9:0]                bidx_q, bidx_d;
	logic [12:0]               time_q, time_d;
	logic [7:0]                rstat_q, rstat_d;
	logic [6:0]                held_q, held_d;
	logic [1:0]                need_q, need_d;
	logic                      cont_q, cont_d;
	logic                      drop_q, drop_d;
	logic [SYSEX_POS_BITS-1:0] sxpos_q [NUM_PORTS];

	// Result register
	logic                      out_valid_q;

	// Decode signals
	logic                      out_free, proc, port_ok, last;
	logic [PIDX_W-1:0]         pidx;
	logic [bmp_pkg::LEN_W-1:0] len_c, idx;
	logic [SYSEX_POS_BITS-1:0] pos_rd;
	logic [31:0]               pos_w;
	logic                      sx_we;
	logic [SYSEX_POS_BITS-1:0] sx_wd;
	logic                      ts_go, sx_go, fail_go, put_go;
	logic [2:0]                fail_code;
	logic [1:0]                n_rs, n_b;
	logic [7:0]                r_status;
	logic [6:0]                r_d1, r_d2;
	logic [1:0]                r_cnt;
	logic                      r_sx, res_v;
	logic [15:0]               r_off;

	// Handshake: a byte decodes when the result register can take a result.
	assign out_free = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			port_s1  <= port_index;
			byte_s1  <= data_byte;
			len_s1   <= packet_length;
			first_s1 <= first_of_packet;
		end
	end

	// Length clamp, position within packet and per-port sysex offset lookup.
	assign len_c   = (bmp_pkg::LEN_W'(len_s1) > MAX_LEN) ? MAX_LEN : bmp_pkg::LEN_W'(len_s1);
	assign idx     = bmp_pkg::LEN_W'(bidx_q) + bmp_pkg::LEN_W'(1);
	assign last    = (idx + bmp_pkg::LEN_W'(1)) >= len_c;
	assign port_ok = 32'(port_s1) < NUM_PORTS;
	assign pidx    = PIDX_W'(port_s1);
	assign pos_rd  = sxpos_q[pidx];
	assign pos_w   = 32'(pos_rd);
	assign n_rs    = bmp_pkg::msg_size(rstat_q);
	assign n_b     = bmp_pkg::msg_size(byte_s1);

	// Timestamp-low and sysex data bytes are handled the same way from
	// several phases, so they are picked out ahead of the phase decode.
	always_comb begin
		ts_go = 1'b0;
		sx_go = 1'b0;
		if (proc && port_ok && !first_s1 && phase_q != bmp_pkg::PH_IDLE && !drop_q
				&& idx < len_c) begin
			if (byte_s1[7]) begin
				ts_go = (phase_q == bmp_pkg::PH_EXPECT_TS) || (phase_q == bmp_pkg::PH_SYSEX);
			end else begin
				sx_go = (phase_q == bmp_pkg::PH_EXPECT_TS && cont_q)
					|| (phase_q == bmp_pkg::PH_SYSEX)
					|| (phase_q == bmp_pkg::PH_AFTER_TS && rstat_q == bmp_pkg::STATUS_SYSEX);
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		bidx_d    = bidx_q;
		time_d    = time_q;
		rstat_d   = rstat_q;
		held_d    = held_q;
		need_d    = need_q;
		cont_d    = cont_q;
		drop_d    = drop_q;
		sx_we     = 1'b0;
		sx_wd     = '0;
		fail_go   = 1'b0;
		fail_code = bmp_pkg::ERR_NONE;
		put_go    = 1'b0;
		r_status  = '0;
		r_d1      = '0;
		r_d2      = '0;
		r_cnt     = '0;
		r_sx      = 1'b0;
		r_off     = '0;

		if (proc) begin
			if (!port_ok) begin
				if (first_s1) begin
					phase_d = bmp_pkg::PH_IDLE;
				end
			end else if (first_s1) begin
				// header byte: fresh packet context
				bidx_d  = '0;
				drop_d  = 1'b0;
				held_d  = '0;
				need_d  = '0;
				cont_d  = 1'b0;
				rstat_d = '0;
				time_d  = '0;
				if (len_c < bmp_pkg::LEN_W'(bmp_pkg::MIN_PKT_LEN)) begin
					sx_we     = 1'b1;
					fail_go   = 1'b1;
					fail_code = bmp_pkg::ERR_TOO_SHORT;
				end else if (!byte_s1[7]) begin
					sx_we     = 1'b1;
					fail_go   = 1'b1;
					fail_code = bmp_pkg::ERR_NO_TS_HIGH;
				end else begin
					time_d  = {byte_s1[5:0], 7'd0};
					cont_d  = 1'b1;
					phase_d = bmp_pkg::PH_EXPECT_TS;
				end
			end else if (phase_q != bmp_pkg::PH_IDLE && !drop_q) begin
				if (idx >= len_c) begin
					phase_d = bmp_pkg::PH_IDLE;
				end else begin
					bidx_d = idx[9:0];
					if (ts_go) begin
						time_d  = {time_q[12:7], byte_s1[6:0]};
						cont_d  = 1'b0;
						sx_we   = 1'b1;
						phase_d = bmp_pkg::PH_AFTER_TS;
						if (last && rstat_q != bmp_pkg::STATUS_SYSEX) begin
							if (n_rs != 2'd0) begin
								fail_go   = 1'b1;
								fail_code = bmp_pkg::ERR_INCOMPLETE;
							end else begin
								put_go   = 1'b1;
								r_status = rstat_q;
							end
						end
					end else if (sx_go) begin
						if (phase_q == bmp_pkg::PH_EXPECT_TS) begin
							rstat_d = bmp_pkg::STATUS_SYSEX;
						end
						sx_we    = !(&pos_rd);   // saturate at all ones
						sx_wd    = pos_rd + SYSEX_POS_BITS'(1);
						phase_d  = bmp_pkg::PH_SYSEX;
						put_go   = 1'b1;
						r_status = bmp_pkg::STATUS_SYSEX;
						r_d1     = byte_s1[6:0];
						r_sx     = 1'b1;
						r_off    = (pos_w > 32'h0000_FFFF) ? 16'hFFFF : pos_w[15:0];
					end else begin
						case (phase_q)
							bmp_pkg::PH_EXPECT_TS: begin
								// data byte with no timestamp-low in front
								fail_go   = 1'b1;
								fail_code = bmp_pkg::ERR_NO_TS_LOW;
							end
							bmp_pkg::PH_AFTER_TS: begin
								if (byte_s1[7]) begin
									rstat_d = byte_s1;
									if (byte_s1 == bmp_pkg::STATUS_SYSEX) begin
										phase_d = bmp_pkg::PH_SYSEX;
									end else if (n_b == 2'd0) begin
										put_go   = 1'b1;
										r_status = byte_s1;
										phase_d  = bmp_pkg::PH_EXPECT_TS;
									end else if ((idx + bmp_pkg::LEN_W'(1)
											+ bmp_pkg::LEN_W'(n_b)) > len_c) begin
										fail_go   = 1'b1;
										fail_code = bmp_pkg::ERR_INCOMPLETE;
									end else begin
										need_d  = n_b;
										phase_d = bmp_pkg::PH_DATA;
									end
								end else if (n_rs == 2'd0) begin
									fail_go   = 1'b1;
									fail_code = bmp_pkg::ERR_NO_TS_LOW;
								end else if ((idx + bmp_pkg::LEN_W'(n_rs)) > len_c) begin
									fail_go   = 1'b1;
									fail_code = bmp_pkg::ERR_INCOMPLETE;
								end else if (n_rs == 2'd1) begin
									put_go   = 1'b1;
									r_status = rstat_q;
									r_d1     = byte_s1[6:0];
									r_cnt    = 2'd1;
									phase_d  = bmp_pkg::PH_EXPECT_TS;
								end else begin
									held_d  = byte_s1[6:0];
									need_d  = 2'd1;
									phase_d = bmp_pkg::PH_DATA;
								end
							end
							bmp_pkg::PH_DATA: begin
								if (need_q >= 2'd2) begin
									held_d = byte_s1[6:0];
									need_d = 2'd1;
								end else begin
									put_go   = 1'b1;
									r_status = rstat_q;
									if (n_rs == 2'd2) begin
										r_d1  = held_q;
										r_d2  = byte_s1[6:0];
										r_cnt = 2'd2;
									end else begin
										r_d1  = byte_s1[6:0];
										r_cnt = 2'd1;
									end
									need_d  = 2'd0;
									phase_d = bmp_pkg::PH_EXPECT_TS;
								end
							end
							default: begin
								phase_d = bmp_pkg::PH_IDLE;
							end
						endcase
					end
					if (last) begin
						phase_d = bmp_pkg::PH_IDLE;
					end
				end
			end
			if (fail_go) begin
				drop_d  = 1'b1;
				phase_d = bmp_pkg::PH_IDLE;
			end
		end
		res_v = put_go || fail_go;
	end

	// Parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmp_pkg::PH_IDLE;
			bidx_q  <= '0;
			time_q  <= '0;
			rstat_q <= '0;
			held_q  <= '0;
			need_q  <= '0;
			cont_q  <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bidx_q  <= bidx_d;
			time_q  <= time_d;
			rstat_q <= rstat_d;
			held_q  <= held_d;
			need_q  <= need_d;
			cont_q  <= cont_d;
			drop_q  <= drop_d;
		end
	end

	// Per-port sysex offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				sxpos_q[i] <= '0;
			end
		end else if (sx_we) begin
			sxpos_q[pidx] <= sx_wd;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_v;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_v) begin
			out_port      <= port_s1;
			timestamp     <= put_go ? time_d : 13'd0;
			msg_status    <= r_status;
			data_first    <= r_d1;
			data_second   <= r_d2;
			data_count    <= r_cnt;
			is_sysex_byte <= r_sx;
			sysex_offset  <= r_off;
			error_code    <= fail_go ? fail_code : bmp_pkg::ERR_NONE;
		end
	end

	// Assertions
	`BMP_ASSERT_NOW(a_err_clean, clk, arst_n,
		out_valid && error_code != bmp_pkg::ERR_NONE,
		timestamp == 13'd0 && !is_sysex_byte && data_count == 2'd0 && msg_status == 8'd0,
		"error result carries message fields")
	`BMP_ASSERT_NOW(a_sysex_form, clk, arst_n,
		out_valid && is_sysex_byte,
		msg_status == bmp_pkg::STATUS_SYSEX && data_count == 2'd0
			&& error_code == bmp_pkg::ERR_NONE,
		"malformed sysex byte result")
	`BMP_ASSERT_NOW(a_data_need, clk, arst_n,
		phase_q == bmp_pkg::PH_DATA,
		need_q != 2'd0,
		"data phase with no bytes outstanding")
	`BMP_ASSERT_NEXT(a_drop_idle, clk, arst_n,
		proc && res_v && fail_go,
		drop_q && phase_q == bmp_pkg::PH_IDLE,
		"packet not dropped after error")

endmodule

`default_nettype wire

@@ verif/ble_midi_packet_parser_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// BLE MIDI packet parser testbench
// Feeds packet bytes with random bursts and output stalls, predicts each
// message, sysex byte and error report, and checks every result in order.
// ---------------------------------------------------------------------------

module ble_midi_packet_parser_tb;

	localparam int PORT_COUNT = 4;
	localparam int LEN_LIMIT  = 512;   // longer length fields are capped here
	localparam int POS_BITS   = 16;
	localparam int RANDOM_BYTES = 750;
	localparam int DRAIN_CYCLES = 5000;

	// Data bytes after a status: channel table by bits 6..4, system table by 3..0.
	localparam logic [1:0] CHAN_LEN [8] = '{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0};
	localparam logic [1:0] SYS_LEN [16] = '{2'd1, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

	typedef struct {
		logic [1:0] port;
		logic [7:0] value;
		logic [9:0] len;
		logic       first;
	} midi_byte_t;

	typedef struct {
		logic [1:0]  port;
		logic [12:0] ts;
		logic [7:0]  status;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [1:0]  cnt;
		logic        sx;
		logic [15:0] off;
		logic [2:0]  err;
	} midi_result_t;

	typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

	function automatic logic [1:0] data_len(input logic [7:0] st);
		logic [1:0] n;
		n = CHAN_LEN[st[6:4]];
		if (n == 2'd0)
			n = SYS_LEN[st[3:0]];
		return n;
	endfunction

	// -----------------------------------------------------------------------
	// Scoreboard: decodes every accepted byte into the results it should
	// cause and matches the block's results against them in order.
	// -----------------------------------------------------------------------
	class ble_midi_scoreboard;
		midi_result_t expected_events[$];
		int failures = 0;
		int bytes_taken = 0;
		int results_checked = 0;
		int sysex_checked = 0;
		int errors_checked = 0;

		// decoder state, one copy of the block's own
		logic [15:0]      sx_pos [PORT_COUNT];
		logic [9:0]       byte_idx;
		logic [12:0]      ts_reg;
		logic [7:0]       run_status;
		bmp_pkg::phase_t  phase;
		logic [6:0]       held;
		logic [1:0]       need;
		logic             cont;
		logic             drop;
		logic [1:0]       port;

		function new();
			foreach (sx_pos[i])
				sx_pos[i] = '0;
			byte_idx = '0;
			ts_reg = '0;
			run_status = '0;
			phase = bmp_pkg::PH_IDLE;
			held = '0;
			need = '0;
			cont = 1'b0;
			drop = 1'b0;
			port = '0;
		endfunction

		function void emit(logic [7:0] st, logic [6:0] d1, logic [6:0] d2, logic [1:0] cnt,
			logic sx, logic [15:0] off, logic [2:0] err, bit stamped);
			midi_result_t r;
			r.port = port;
			r.ts = stamped ? ts_reg : 13'd0;
			r.status = st;
			r.d1 = d1;
			r.d2 = d2;
			r.cnt = cnt;
			r.sx = sx;
			r.off = off;
			r.err = err;
			expected_events.push_back(r);
		endfunction

		// error report carries only port and code; rest of packet is dropped
		function void fail(logic [2:0] code);
			drop = 1'b1;
			phase = bmp_pkg::PH_IDLE;
			emit(8'h00, 7'h00, 7'h00, 2'd0, 1'b0, 16'h0000, code, 1'b0);
		endfunction

		function void sysex_out(logic [7:0] b);
			logic [15:0] pos;
			pos = sx_pos[port];
			if (pos != 16'hFFFF)
				sx_pos[port] = pos + 16'd1;
			phase = bmp_pkg::PH_SYSEX;
			emit(bmp_pkg::STATUS_SYSEX, b[6:0], 7'h00, 2'd0, 1'b1, pos, bmp_pkg::ERR_NONE,
				1'b1);
		endfunction

		// timestamp-low byte; as the packet's last byte it may repeat or fail
		function void ts_low(logic [7:0] b, bit last);
			ts_reg = {ts_reg[12:7], b[6:0]};
			cont = 1'b0;
			sx_pos[port] = '0;
			phase = bmp_pkg::PH_AFTER_TS;
			if (!last || run_status == bmp_pkg::STATUS_SYSEX)
				return;
			if (data_len(run_status) != 2'd0)
				fail(bmp_pkg::ERR_INCOMPLETE);
			else
				emit(run_status, 7'h00, 7'h00, 2'd0, 1'b0, 16'h0000, bmp_pkg::ERR_NONE, 1'b1);
		endfunction

		function void decode_byte(midi_byte_t it);
			int unsigned len;
			int unsigned idx;
			int unsigned n;
			bit last;
			bytes_taken++;
			len = (it.len > LEN_LIMIT) ? LEN_LIMIT : it.len;
			port = it.port;
			if (it.first) begin
				byte_idx = '0;
				drop = 1'b0;
				held = '0;
				need = '0;
				cont = 1'b0;
				run_status = '0;
				ts_reg = '0;
				if (len < 3) begin
					sx_pos[port] = '0;
					fail(bmp_pkg::ERR_TOO_SHORT);
					return;
				end
				if (!it.value[7]) begin
					sx_pos[port] = '0;
					fail(bmp_pkg::ERR_NO_TS_HIGH);
					return;
				end
				ts_reg = {it.value[5:0], 7'd0};
				cont = 1'b1;
				phase = bmp_pkg::PH_EXPECT_TS;
				return;
			end
			if (phase == bmp_pkg::PH_IDLE || drop)
				return;
			idx = byte_idx + 1;
			if (idx >= len) begin
				phase = bmp_pkg::PH_IDLE;
				return;
			end
			byte_idx = idx[9:0];
			last = (idx + 1) >= len;

			case (phase)
				bmp_pkg::PH_EXPECT_TS: begin
					if (it.value[7])
						ts_low(it.value, last);
					else if (cont) begin
						// continued packet: data right after the header
						run_status = bmp_pkg::STATUS_SYSEX;
						sysex_out(it.value);
					end else
						fail(bmp_pkg::ERR_NO_TS_LOW);
				end
				bmp_pkg::PH_SYSEX: begin
					if (it.value[7])
						ts_low(it.value, last);
					else
						sysex_out(it.value);
				end
				bmp_pkg::PH_AFTER_TS: begin
					if (it.value[7]) begin
						run_status = it.value;
						n = data_len(it.value);
						if (it.value == bmp_pkg::STATUS_SYSEX)
							phase = bmp_pkg::PH_SYSEX;
						else if (n == 0) begin
							emit(it.value, 7'h00, 7'h00, 2'd0, 1'b0, 16'h0000,
								bmp_pkg::ERR_NONE, 1'b1);
							phase = bmp_pkg::PH_EXPECT_TS;
						end else if (idx + 1 + n > len)
							fail(bmp_pkg::ERR_INCOMPLETE);
						else begin
							need = n[1:0];
							phase = bmp_pkg::PH_DATA;
						end
					end else if (run_status == bmp_pkg::STATUS_SYSEX) begin
						sysex_out(it.value);
					end else begin
						// running status; status 0 counts as a two-byte message
						n = data_len(run_status);
						if (n == 0)
							fail(bmp_pkg::ERR_NO_TS_LOW);
						else if (idx + n > len)
							fail(bmp_pkg::ERR_INCOMPLETE);
						else if (n == 1) begin
							emit(run_status, it.value[6:0], 7'h00, 2'd1, 1'b0, 16'h0000,
								bmp_pkg::ERR_NONE, 1'b1);
							phase = bmp_pkg::PH_EXPECT_TS;
						end else begin
							held = it.value[6:0];
							need = 2'd1;
							phase = bmp_pkg::PH_DATA;
						end
					end
				end
				bmp_pkg::PH_DATA: begin
					if (need >= 2'd2) begin
						held = it.value[6:0];
						need = 2'd1;
					end else begin
						if (data_len(run_status) == 2'd2)
							emit(run_status, held, it.value[6:0], 2'd2, 1'b0, 16'h0000,
								bmp_pkg::ERR_NONE, 1'b1);
						else
							emit(run_status, it.value[6:0], 7'h00, 2'd1, 1'b0, 16'h0000,
								bmp_pkg::ERR_NONE, 1'b1);
						need = 2'd0;
						phase = bmp_pkg::PH_EXPECT_TS;
					end
				end
				default: phase = bmp_pkg::PH_IDLE;
			endcase

			if (last)
				phase = bmp_pkg::PH_IDLE;
		endfunction

		function string show(midi_result_t r);
			return $sformatf({"port=%0d ts=%0d status=%02h d1=%02h d2=%02h cnt=%0d",
				" sysex=%0b off=%0d err=%0d"},
				r.port, r.ts, r.status, r.d1, r.d2, r.cnt, r.sx, r.off, r.err);
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		function void check_event(midi_result_t got);
			midi_result_t want;
			results_checked++;
			if (got.sx)
				sysex_checked++;
			if (got.err != bmp_pkg::ERR_NONE)
				errors_checked++;
			if (expected_events.size() == 0) begin
				report({"unexpected result ", show(got)});
				return;
			end
			want = expected_events.pop_front();
			if (got.port !== want.port || got.ts !== want.ts || got.status !== want.status ||
				got.d1 !== want.d1 || got.d2 !== want.d2 || got.cnt !== want.cnt ||
				got.sx !== want.sx || got.off !== want.off || got.err !== want.err)
				report({"mismatch: expected ", show(want), " got ", show(got)});
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// DUT and its signals
	// -----------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  port_index;
	logic [7:0]  data_byte;
	logic [9:0]  packet_length;
	logic        first_of_packet;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  out_port;
	logic [12:0] timestamp;
	logic [7:0]  msg_status;
	logic [6:0]  data_first;
	logic [6:0]  data_second;
	logic [1:0]  data_count;
	logic        is_sysex_byte;
	logic [15:0] sysex_offset;
	logic [2:0]  error_code;

	ble_midi_packet_parser #(
		.NUM_PORTS      (PORT_COUNT),
		.MAX_PACKET_LEN (LEN_LIMIT),
		.SYSEX_POS_BITS (POS_BITS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.port_index      (port_index),
		.data_byte       (data_byte),
		.packet_length   (packet_length),
		.first_of_packet (first_of_packet),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_port        (out_port),
		.timestamp       (timestamp),
		.msg_status      (msg_status),
		.data_first      (data_first),
		.data_second     (data_second),
		.data_count      (data_count),
		.is_sysex_byte   (is_sysex_byte),
		.sysex_offset    (sysex_offset),
		.error_code      (error_code)
	);

	ble_midi_scoreboard sb;
	midi_byte_t pkt_bytes[$];   // packet being assembled for the sender
	int burst_left;             // transfers left before the next sender gap

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit: far above the slowest legal run (about 800 transfers, each
	// at worst a sender gap plus a long receiver stall).
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Receiver: stall pattern switches between free flow, light and heavy
	// random stalls, and a periodic stall, each for a random stretch.
	// Driven on the falling edge, so stable at the sampling edge.
	// -----------------------------------------------------------------------
	initial begin
		flow_mode_t mode;
		int span;
		int tick;
		out_stall = 1'b0;
		tick = 0;
		forever begin
			mode = flow_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					FLOW_FREE:  out_stall <= 1'b0;
					FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:    out_stall <= ((tick % 11) < 4);
				endcase
			end
		end
	end

	// Result monitor: a transfer happens at a rising edge with valid and no stall.
	always @(posedge clk) begin
		midi_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_port, timestamp, msg_status, data_first, data_second, data_count,
				is_sysex_byte, sysex_offset, error_code};
			sb.check_event(got);
		end
	end

	// -----------------------------------------------------------------------
	// Sender. Each call starts at a falling edge and returns at the rising
	// edge where the byte transferred. Bursts of random length are broken
	// by random gaps; a long burst now and then keeps valid high unbroken.
	// -----------------------------------------------------------------------
	task automatic send_byte(input logic [1:0] p, input logic [7:0] v, input logic [9:0] len,
		input logic first);
		midi_byte_t item;
		item = '{p, v, len, first};
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250)
				: $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		port_index <= p;
		data_byte <= v;
		packet_length <= len;
		first_of_packet <= first;
		// payload holds until the transfer
		do @(posedge clk); while (in_stall);
		sb.decode_byte(item);
		burst_left--;
	endtask

	// Sender goes quiet until every predicted result has come out or the drain limit runs out.
	task automatic wait_for_results();
		int waited;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (sb.expected_events.size() != 0 && waited < DRAIN_CYCLES) begin
			@(negedge clk);
			waited++;
		end
		if (sb.expected_events.size() != 0) begin
			sb.report($sformatf("%0d expected results never arrived",
				sb.expected_events.size()));
			sb.expected_events.delete();
		end
	endtask

	function automatic logic [7:0] pick_status();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'($urandom_range(8'h80, 8'hEF));   // channel voice
		if (r < 70)
			return bmp_pkg::STATUS_SYSEX;
		return 8'($urandom_range(8'hF1, 8'hFF));       // system common / real-time
	endfunction

	// Assembles one packet: header, optional continuation data, then
	// timestamped messages (new status or running status, some noise),
	// cut to the packet length as capped by the block.
	function automatic void build_packet(input logic [1:0] p, input logic [9:0] len,
		input bit bad_header);
		logic [7:0] body[$];
		logic [7:0] st;
		int unsigned want;
		int unsigned n;
		want = (len > LEN_LIMIT) ? LEN_LIMIT : len;
		st = 8'h00;
		pkt_bytes.delete();
		pkt_bytes.push_back(midi_byte_t'{p, {~bad_header, 7'($urandom)}, len, 1'b1});
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 6)) body.push_back({1'b0, 7'($urandom)});
		while (body.size() + 1 < want) begin
			body.push_back({1'b1, 7'($urandom)});
			if ($urandom_range(0, 9) == 0) begin
				body.push_back(8'($urandom));
			end else begin
				if ($urandom_range(0, 2) != 0) begin
					st = pick_status();
					body.push_back(st);
				end
				n = (st == bmp_pkg::STATUS_SYSEX) ? $urandom_range(0, 6) : data_len(st);
				repeat (n) body.push_back({1'b0, 7'($urandom)});
			end
		end
		for (int i = 0; i + 1 < want; i++)
			pkt_bytes.push_back(midi_byte_t'{p, body[i], len, 1'b0});
	endfunction

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		int random_count;
		int packets;
		int unsigned cut;
		int unsigned shape;
		logic [1:0] p;
		logic [9:0] len;

		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		port_index = '0;
		data_byte = '0;
		packet_length = '0;
		first_of_packet = 1'b0;
		burst_left = 0;
		random_count = 0;
		packets = 7;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// byte with no packet open: ignored
		send_byte(2'd0, 8'h90, 10'd5, 1'b0);
		// length below three: too short
		send_byte(2'd1, 8'h80, 10'd2, 1'b1);
		// header with bit 7 clear: timestamp high missing
		send_byte(2'd2, 8'h3F, 10'd5, 1'b1);
		// full-scale timestamp, note on with extreme data bytes
		send_byte(2'd3, 8'hBF, 10'd5, 1'b1);
		send_byte(2'd3, 8'hFF, 10'd5, 1'b0);
		send_byte(2'd3, 8'h90, 10'd5, 1'b0);
		send_byte(2'd3, 8'h7F, 10'd5, 1'b0);
		send_byte(2'd3, 8'h00, 10'd5, 1'b0);
		// sysex start, then a continued packet whose offsets carry on
		send_byte(2'd0, 8'h80, 10'd5, 1'b1);
		send_byte(2'd0, 8'h80, 10'd5, 1'b0);
		send_byte(2'd0, bmp_pkg::STATUS_SYSEX, 10'd5, 1'b0);
		send_byte(2'd0, 8'h01, 10'd5, 1'b0);
		send_byte(2'd0, 8'h02, 10'd5, 1'b0);
		send_byte(2'd0, 8'h85, 10'd3, 1'b1);
		send_byte(2'd0, 8'h03, 10'd3, 1'b0);
		send_byte(2'd0, 8'h04, 10'd3, 1'b0);
		// real-time message, repeated by a trailing timestamp
		send_byte(2'd1, 8'h80, 10'd4, 1'b1);
		send_byte(2'd1, 8'h80, 10'd4, 1'b0);
		send_byte(2'd1, 8'hF8, 10'd4, 1'b0);
		send_byte(2'd1, 8'h90, 10'd4, 1'b0);
		// data byte where a timestamp belongs, rest of packet dropped
		send_byte(2'd2, 8'h80, 10'd5, 1'b1);
		send_byte(2'd2, 8'h80, 10'd5, 1'b0);
		send_byte(2'd2, 8'hF6, 10'd5, 1'b0);
		send_byte(2'd2, 8'h05, 10'd5, 1'b0);
		send_byte(2'd2, 8'h06, 10'd5, 1'b0);
		wait_for_results();

		// --- random ---
		// One full packet whose length field is past the cap: bytes beyond
		// the capped length and the trailing extras must be ignored.
		p = 2'($urandom_range(0, 3));
		len = 10'($urandom_range(600, 1023));
		build_packet(p, len, 1'b0);
		repeat (3) pkt_bytes.push_back(midi_byte_t'{p, 8'($urandom), len, 1'b0});
		foreach (pkt_bytes[i])
			send_byte(pkt_bytes[i].port, pkt_bytes[i].value, pkt_bytes[i].len,
				pkt_bytes[i].first);
		random_count += pkt_bytes.size();
		packets++;

		while (random_count < RANDOM_BYTES) begin
			p = 2'($urandom_range(0, 3));
			shape = $urandom_range(0, 99);
			if (shape < 4)
				len = 10'($urandom_range(0, 2));
			else if (shape < 8)
				len = 10'($urandom_range(513, 1023));
			else
				len = 10'($urandom_range(3, 24));
			build_packet(p, len, $urandom_range(0, 19) == 0);
			// oversize packets and some others are abandoned by the next header
			if (shape >= 4 && shape < 8)
				cut = $urandom_range(2, 30);
			else if ($urandom_range(0, 9) == 0)
				cut = $urandom_range(1, pkt_bytes.size());
			else
				cut = pkt_bytes.size();
			while (pkt_bytes.size() > cut)
				void'(pkt_bytes.pop_back());
			// stray bytes past the end of the packet
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3))
					pkt_bytes.push_back(midi_byte_t'{p, 8'($urandom), len, 1'b0});
			foreach (pkt_bytes[i])
				send_byte(pkt_bytes[i].port, pkt_bytes[i].value, pkt_bytes[i].len,
					pkt_bytes[i].first);
			random_count += pkt_bytes.size();
			packets++;
			if (packets % 20 == 0)
				wait_for_results();
		end

		// --- wind down ---
		wait_for_results();
		repeat (20) @(posedge clk);

		$display("Covered %0d packets in %0d byte transfers; %0d results compared.",
			packets, sb.bytes_taken, sb.results_checked);
		$display("Of those, %0d sysex bytes and %0d error reports; %0d mismatches.",
			sb.sysex_checked, sb.errors_checked, sb.failures);
		if (sb.failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
